// ----- hw/rtl/ept_page_table_map_and_walk_unit_assert.svh -----
// ----------------------------------------------------------------------------
// EPT map and walk unit: assertion macros
// Shared shorthand for the concurrent checks on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef EPT_PAGE_TABLE_MAP_AND_WALK_UNIT_ASSERT_SVH
`define EPT_PAGE_TABLE_MAP_AND_WALK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ept_pkg.sv -----
// ----------------------------------------------------------------------------
// EPT map and walk unit: package
// Sizes, codes, payload types and the level index helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ept_pkg;

    // Table geometry
    localparam int TABLE_PAGES   = 16;
    localparam int LEVELS        = 4;
    localparam int INDEX_BITS    = 9;
    localparam int PAGE_BITS     = $clog2(TABLE_PAGES);
    localparam int SLOT_BITS     = PAGE_BITS + INDEX_BITS;
    localparam int STORE_DEPTH   = TABLE_PAGES << INDEX_BITS;
    localparam int NFP_BITS      = PAGE_BITS + 1;

    // Field widths
    localparam int FRAME_BITS    = 36;
    localparam int ENTRY_BITS    = 64;
    localparam int LEVEL_BITS    = 3;
    localparam int SLOT_OUT_BITS = 13;
    localparam int FRAME_SHIFT   = 12;
    localparam int PTR_BITS      = ENTRY_BITS - FRAME_SHIFT;
    localparam int LARGE_BIT     = 7;

    localparam logic [FRAME_BITS-1:0] BASE_RESET  = FRAME_BITS'(256);
    localparam logic [ENTRY_BITS-1:0] RWX_MASK    = ENTRY_BITS'(7);
    localparam logic [ENTRY_BITS-1:0] MEM_TYPE_WB = ENTRY_BITS'(8'h30);

    // Operation codes
    localparam logic [1:0] OP_MAP     = 2'd0;
    localparam logic [1:0] OP_LOOKUP  = 2'd1;
    localparam logic [1:0] OP_PROTECT = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_PAGE = 2'd1;
    localparam logic [1:0] STAT_OUTSIDE = 2'd2;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [FRAME_BITS-1:0] page_number;
        logic                  allow_read;
        logic                  allow_write;
        logic                  allow_exec;
    } ept_in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [ENTRY_BITS-1:0]    entry_value;
        logic [LEVEL_BITS-1:0]    entry_level;
        logic [SLOT_OUT_BITS-1:0] entry_slot;
    } ept_out_t;

    // Table store port request from the walker
    typedef struct packed {
        logic                  we;
        logic [SLOT_BITS-1:0]  waddr;
        logic [ENTRY_BITS-1:0] wdata;
        logic                  re;
        logic [SLOT_BITS-1:0]  raddr;
    } ept_mem_req_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_RESP
    } ept_state_t;

    // Index of a frame number within the table at the given level (1 = leaf)
    function automatic logic [INDEX_BITS-1:0] level_index(
        input logic [FRAME_BITS-1:0] pfn,
        input logic [LEVEL_BITS-1:0] level
    );
        logic [FRAME_BITS-1:0] shifted;
        shifted = pfn >> (INDEX_BITS * (int'(level) - 1));
        return shifted[INDEX_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ept_ram.sv -----
// ----------------------------------------------------------------------------
// EPT generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ept_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ept_walk.sv -----
// ----------------------------------------------------------------------------
// EPT walk sequencer
// Clears the store, walks the levels, allocates tables and writes entries.
// ----------------------------------------------------------------------------
`default_nettype none

module ept_walk (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ept_pkg::FRAME_BITS-1:0]  cfg_wr_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire ept_pkg::ept_in_t                in_data,
    output ept_pkg::ept_mem_req_t                mem_req,
    input  wire logic [ept_pkg::ENTRY_BITS-1:0]  mem_rdata,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output ept_pkg::ept_out_t                    res_data
);

    localparam logic [ept_pkg::SLOT_BITS-1:0] LAST_SLOT =
        ept_pkg::SLOT_BITS'(ept_pkg::STORE_DEPTH - 1);
    localparam logic [ept_pkg::LEVEL_BITS-1:0] LEVEL_TOP = ept_pkg::LEVEL_BITS'(ept_pkg::LEVELS);
    localparam logic [ept_pkg::LEVEL_BITS-1:0] LEVEL_ONE = ept_pkg::LEVEL_BITS'(1);

    ept_pkg::ept_state_t                  state_reg, state_next;
    logic [1:0]                           op_reg, op_next;
    logic [ept_pkg::FRAME_BITS-1:0]       pfn_reg, pfn_next;
    logic [2:0]                           prot_reg, prot_next;
    logic [ept_pkg::LEVEL_BITS-1:0]       level_reg, level_next;
    logic [ept_pkg::SLOT_BITS-1:0]        slot_reg, slot_next;
    logic [ept_pkg::NFP_BITS-1:0]         nfp_reg, nfp_next;
    logic [ept_pkg::FRAME_BITS-1:0]       base_reg;
    logic [ept_pkg::SLOT_BITS-1:0]        clr_cnt_reg, clr_cnt_next;
    logic                                 fwd_valid_reg, fwd_valid_next;
    logic [ept_pkg::ENTRY_BITS-1:0]       fwd_data_reg, fwd_data_next;
    ept_pkg::ept_out_t                    res_reg, res_next;

    logic [ept_pkg::ENTRY_BITS-1:0]       entry;
    logic [ept_pkg::PTR_BITS:0]           ptr_diff;
    logic                                 child_ok;
    logic [ept_pkg::FRAME_BITS:0]         alloc_frame;
    logic [ept_pkg::ENTRY_BITS-1:0]       alloc_entry;
    logic [ept_pkg::ENTRY_BITS-1:0]       leaf_entry;
    logic [ept_pkg::ENTRY_BITS-1:0]       prot_entry;
    logic                                 descend;
    logic [ept_pkg::PAGE_BITS-1:0]        desc_page;
    logic                                 finish;
    logic [1:0]                           fin_status;
    logic [ept_pkg::ENTRY_BITS-1:0]       fin_value;

    // Take the entry just written when the read hit the same slot
    assign entry = fwd_valid_reg ? fwd_data_reg : mem_rdata;

    assign ptr_diff = {1'b0, entry[ept_pkg::ENTRY_BITS-1:ept_pkg::FRAME_SHIFT]}
                    - (ept_pkg::PTR_BITS + 1)'(base_reg);
    assign child_ok = !ptr_diff[ept_pkg::PTR_BITS]
                    && (ptr_diff[ept_pkg::PTR_BITS-1:0] < ept_pkg::PTR_BITS'(ept_pkg::TABLE_PAGES));

    assign alloc_frame = {1'b0, base_reg} + (ept_pkg::FRAME_BITS + 1)'(nfp_reg);
    assign alloc_entry = (ept_pkg::ENTRY_BITS'(alloc_frame) << ept_pkg::FRAME_SHIFT)
                       | ept_pkg::RWX_MASK;
    assign leaf_entry  = (ept_pkg::ENTRY_BITS'(pfn_reg) << ept_pkg::FRAME_SHIFT)
                       | ept_pkg::MEM_TYPE_WB | ept_pkg::RWX_MASK;
    assign prot_entry  = {entry[ept_pkg::ENTRY_BITS-1:3], prot_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ept_pkg::ST_CLEAR;
            nfp_reg       <= ept_pkg::NFP_BITS'(1);
            base_reg      <= ept_pkg::BASE_RESET;
            clr_cnt_reg   <= '0;
            fwd_valid_reg <= 1'b0;
            level_reg     <= LEVEL_TOP;
        end
        else
        begin
            state_reg     <= state_next;
            nfp_reg       <= nfp_next;
            clr_cnt_reg   <= clr_cnt_next;
            fwd_valid_reg <= fwd_valid_next;
            level_reg     <= level_next;
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pfn_reg      <= pfn_next;
        prot_reg     <= prot_next;
        slot_reg     <= slot_next;
        fwd_data_reg <= fwd_data_next;
        res_reg      <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pfn_next       = pfn_reg;
        prot_next      = prot_reg;
        level_next     = level_reg;
        slot_next      = slot_reg;
        nfp_next       = nfp_reg;
        clr_cnt_next   = clr_cnt_reg;
        fwd_valid_next = 1'b0;
        fwd_data_next  = fwd_data_reg;
        res_next       = res_reg;
        mem_req        = '0;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        descend        = 1'b0;
        desc_page      = '0;
        finish         = 1'b0;
        fin_status     = ept_pkg::STAT_OK;
        fin_value      = entry;

        unique case (state_reg)
            ept_pkg::ST_CLEAR:
            begin
                // Zero one entry per cycle
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_cnt_reg;
                mem_req.wdata = '0;
                clr_cnt_next  = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = ept_pkg::ST_IDLE;
                end
            end

            ept_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next       = in_data.opcode;
                    pfn_next      = in_data.page_number;
                    prot_next     = {in_data.allow_exec, in_data.allow_write, in_data.allow_read};
                    level_next    = LEVEL_TOP;
                    slot_next     = {ept_pkg::PAGE_BITS'(0),
                                     ept_pkg::level_index(in_data.page_number, LEVEL_TOP)};
                    mem_req.re    = 1'b1;
                    mem_req.raddr = slot_next;
                    state_next    = ept_pkg::ST_WALK;
                end
            end

            ept_pkg::ST_WALK:
            begin
                if (op_reg == ept_pkg::OP_MAP)
                begin
                    priority if (level_reg == LEVEL_ONE)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = slot_reg;
                        mem_req.wdata = leaf_entry;
                        finish        = 1'b1;
                        fin_value     = leaf_entry;
                    end
                    else if (entry == '0)
                    begin
                        if (nfp_reg >= ept_pkg::NFP_BITS'(ept_pkg::TABLE_PAGES))
                        begin
                            finish     = 1'b1;
                            fin_status = ept_pkg::STAT_NO_PAGE;
                        end
                        else
                        begin
                            // Hand out the next table page
                            mem_req.we    = 1'b1;
                            mem_req.waddr = slot_reg;
                            mem_req.wdata = alloc_entry;
                            nfp_next      = nfp_reg + 1'b1;
                            descend       = 1'b1;
                            desc_page     = nfp_reg[ept_pkg::PAGE_BITS-1:0];
                        end
                    end
                    else if (!child_ok)
                    begin
                        finish     = 1'b1;
                        fin_status = ept_pkg::STAT_OUTSIDE;
                    end
                    else
                    begin
                        descend   = 1'b1;
                        desc_page = ptr_diff[ept_pkg::PAGE_BITS-1:0];
                    end
                end
                else
                begin
                    priority if (entry[ept_pkg::LARGE_BIT] || level_reg == LEVEL_ONE)
                    begin
                        finish = 1'b1;
                        if (op_reg == ept_pkg::OP_PROTECT)
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = slot_reg;
                            mem_req.wdata = prot_entry;
                            fin_value     = prot_entry;
                        end
                    end
                    else if (!child_ok)
                    begin
                        finish     = 1'b1;
                        fin_status = ept_pkg::STAT_OUTSIDE;
                    end
                    else
                    begin
                        descend   = 1'b1;
                        desc_page = ptr_diff[ept_pkg::PAGE_BITS-1:0];
                    end
                end

                if (descend)
                begin
                    level_next     = level_reg - LEVEL_ONE;
                    slot_next      = {desc_page,
                                      ept_pkg::level_index(pfn_reg, level_reg - LEVEL_ONE)};
                    mem_req.re     = 1'b1;
                    mem_req.raddr  = slot_next;
                    // Forward the write when the next read lands on the same slot
                    fwd_valid_next = mem_req.we && (mem_req.waddr == slot_next);
                    fwd_data_next  = mem_req.wdata;
                end

                if (finish)
                begin
                    res_next.status      = fin_status;
                    res_next.entry_value = fin_value;
                    res_next.entry_level = level_reg;
                    res_next.entry_slot  = ept_pkg::SLOT_OUT_BITS'(slot_reg);
                    state_next           = ept_pkg::ST_RESP;
                end
            end

            ept_pkg::ST_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ept_pkg::ST_IDLE;
                end
            end
        endcase
    end

    assign res_data = res_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ept_resp_buf.sv -----
// ----------------------------------------------------------------------------
// EPT response buffer
// Output register that decouples the walker from the result consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module ept_resp_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               res_valid,
    output logic                    res_ready,
    input  wire ept_pkg::ept_out_t  res_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ept_pkg::ept_out_t       out_data
);

    logic              out_valid_reg, out_valid_next;
    ept_pkg::ept_out_t out_data_reg;
    logic              load;

    // Accept a new result when empty or when the held one leaves this cycle
    assign res_ready      = !out_valid_reg || out_ready;
    assign load           = res_valid && res_ready;
    assign out_valid_next = load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ept_page_table_map_and_walk_unit.sv -----
// ----------------------------------------------------------------------------
// EPT page table map and walk unit
// Four-level page table kept in a local store, with map, lookup and protect.
// ----------------------------------------------------------------------------
// The unit holds a four-level page table of TABLE_PAGES table pages (512
// 64-bit entries each) in one single-port-read, single-port-write RAM with a
// registered read. Table page k lives at frame cfg base + k; page 0 is the
// root, further pages come from a bump allocator and are never freed. Each
// input transaction is one operation on one 4K frame: map (identity leaf,
// missing tables created on the way), lookup (walk stops at a large-page entry
// or at level 1), or protect (lookup, then rewrite the rwx bits); opcode 3
// behaves as lookup. Every input transaction yields exactly one output
// transaction carrying the status, final entry value, level and store slot.
// Sequence: the idle state accepts, the walk state visits each level (at most
// 4), and the response state hands the result to the output register, waiting
// while that register is full, before the unit is idle again. Each level's
// read depends on the entry returned by the previous read through the RAM's
// registered read port, which sets the walk length. A result may wait in the
// output register while the next transaction is already accepted and walked.
// After reset the unit zeroes all STORE_DEPTH entries (8192 by default) one
// entry per cycle, with in_ready held low; the base register may be written
// at any time but only while the unit is idle for defined behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module ept_page_table_map_and_walk_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ept_pkg::FRAME_BITS-1:0] cfg_wr_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire ept_pkg::ept_in_t               in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output ept_pkg::ept_out_t                   out_data
);

    // Walker to store request, store read data back to the walker
    ept_pkg::ept_mem_req_t          mem_req;
    logic [ept_pkg::ENTRY_BITS-1:0] mem_rdata;

    // Walker to output register
    logic                           res_valid;
    logic                           res_ready;
    ept_pkg::ept_out_t              res_data;

    // Sequence the clearing pass, the level walk and the allocator
    ept_walk u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data)
    );

    // Hold every table page of the store
    ept_ram #(
        .WIDTH (ept_pkg::ENTRY_BITS),
        .DEPTH (ept_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    // Hold the finished result until the consumer takes it
    ept_resp_buf u_resp (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/ept_checker.sv -----
// ----------------------------------------------------------------------------
// EPT map and walk unit: port checker
// Tracks transactions in flight and checks the result stream over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ept_page_table_map_and_walk_unit_assert.svh"

module ept_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire ept_pkg::ept_out_t out_data
);

    logic [1:0] pending_reg, pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Count transactions accepted but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `EPT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
    `EPT_ASSERT_IMPLY(a_no_orphan, clk, rst_n, out_valid, pending_reg != 2'd0, "result with no transaction in flight")
    `EPT_ASSERT_IMPLY(a_room, clk, rst_n, in_ready, pending_reg <= 2'd1, "input taken with the walker and output register both full")
    `EPT_ASSERT_IMPLY(a_no_page, clk, rst_n, out_valid && out_data.status == ept_pkg::STAT_NO_PAGE, out_data.entry_value == '0 && out_data.entry_level >= 3'd2, "out-of-pages result on a non-empty or leaf entry")

endmodule

bind ept_page_table_map_and_walk_unit ept_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ----- tb/tb_ept_page_table_map_and_walk_unit.sv -----
// ----------------------------------------------------------------------------
// EPT page table map and walk unit: testbench
// Drives map, lookup and protect transactions through the valid/ready ports,
// mirrors the four-level table store in a scoreboard, and checks every result
// field against the mirrored walk under several idle patterns and bases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ept_page_table_map_and_walk_unit;
    import ept_pkg::*;

    // Opcode three has no name in the package; the unit treats it as a lookup
    localparam logic [1:0]            OP_LOOKUP_ALIAS  = 2'd3;
    localparam logic [FRAME_BITS-1:0] FRAME_MAX        = '1;
    localparam int                    REGION_BITS      = FRAME_BITS - INDEX_BITS;
    localparam int                    CYCLE_LIMIT      = 400000;
    localparam int                    SETTLE_CYCLES    = 16;
    localparam int                    ITEMS_PER_PHASE  = 100;

    // ------------------------------------------------------------------------
    // Scoreboard: a private copy of the table store, the page allocator and
    // the base register, plus the queue of results still owed by the unit.
    // ------------------------------------------------------------------------
    class ept_table_mirror;
        bit [ENTRY_BITS-1:0] entries [STORE_DEPTH];
        int                  next_page;
        bit [FRAME_BITS-1:0] base_frame;
        ept_out_t            owed_results [$];
        int                  mismatches;

        function new();
            next_page  = 1;
            base_frame = BASE_RESET;
            mismatches = 0;
        endfunction

        function void set_base(bit [FRAME_BITS-1:0] frame);
            base_frame = frame;
        endfunction

        function int table_index(bit [FRAME_BITS-1:0] pfn, int level);
            bit [FRAME_BITS-1:0] shifted;
            shifted = pfn >> (INDEX_BITS * (level - 1));
            return int'(shifted[INDEX_BITS-1:0]);
        endfunction

        // True when the entry points at one of the table pages; page gets its number
        function bit follow(bit [ENTRY_BITS-1:0] entry, output int page);
            bit [ENTRY_BITS-1:0] rel;
            rel  = (entry >> FRAME_SHIFT) - ENTRY_BITS'(base_frame);
            page = 0;
            if (rel >= ENTRY_BITS'(TABLE_PAGES))
                return 1'b0;
            page = int'(rel);
            return 1'b1;
        endfunction

        function ept_out_t located(logic [1:0] status, int slot, int level);
            ept_out_t res;
            res.status      = status;
            res.entry_value = entries[slot];
            res.entry_level = LEVEL_BITS'(level);
            res.entry_slot  = SLOT_OUT_BITS'(slot);
            return res;
        endfunction

        // Walk the mirrored table for one request, update it, return the result
        function ept_out_t apply(ept_in_t req);
            int                  page;
            int                  level;
            int                  slot;
            bit [FRAME_BITS-1:0] pfn;
            page  = 0;
            level = LEVELS;
            slot  = 0;
            pfn   = req.page_number;
            if (req.opcode == OP_MAP)
            begin
                while (1'b1)
                begin
                    slot = page * (1 << INDEX_BITS) + table_index(pfn, level);
                    if (level <= 1)
                        break;
                    if (entries[slot] == '0)
                    begin
                        if (next_page >= TABLE_PAGES)
                            return located(STAT_NO_PAGE, slot, level);
                        entries[slot] = ((ENTRY_BITS'(base_frame) + ENTRY_BITS'(next_page))
                                         << FRAME_SHIFT) | RWX_MASK;
                        next_page++;
                    end
                    if (!follow(entries[slot], page))
                        return located(STAT_OUTSIDE, slot, level);
                    level--;
                end
                entries[slot] = (ENTRY_BITS'(pfn) << FRAME_SHIFT) | MEM_TYPE_WB | RWX_MASK;
                return located(STAT_OK, slot, level);
            end
            // Lookup, protect and the alias opcode share the read-only walk
            while (1'b1)
            begin
                slot = page * (1 << INDEX_BITS) + table_index(pfn, level);
                if (entries[slot][LARGE_BIT] || level <= 1)
                    break;
                if (!follow(entries[slot], page))
                    return located(STAT_OUTSIDE, slot, level);
                level--;
            end
            if (req.opcode == OP_PROTECT)
                entries[slot] = (entries[slot] & ~RWX_MASK)
                              | ENTRY_BITS'({req.allow_exec, req.allow_write, req.allow_read});
            return located(STAT_OK, slot, level);
        endfunction

        function void note_request(ept_in_t req);
            owed_results.push_back(apply(req));
        endfunction

        function void check_response(ept_out_t got);
            ept_out_t want;
            if (owed_results.size() == 0)
            begin
                $error("unexpected result: status %0d entry_value %0h slot %0d",
                       got.status, got.entry_value, got.entry_slot);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.entry_value !== want.entry_value)
            begin
                $error("entry_value: expected %0h, got %0h", want.entry_value, got.entry_value);
                mismatches++;
            end
            if (got.entry_level !== want.entry_level)
            begin
                $error("entry_level: expected %0d, got %0d", want.entry_level, got.entry_level);
                mismatches++;
            end
            if (got.entry_slot !== want.entry_slot)
            begin
                $error("entry_slot: expected %0d, got %0d", want.entry_slot, got.entry_slot);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals, clock and the unit under test
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [FRAME_BITS-1:0] cfg_wr_data;
    logic                  in_valid;
    logic                  in_ready;
    ept_in_t               in_data;
    logic                  out_valid;
    logic                  out_ready;
    ept_out_t              out_data;

    ept_table_mirror mirror;
    int              send_idle_pct;
    int              stall_pct;
    int              cycle_count;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    ept_page_table_map_and_walk_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    // ------------------------------------------------------------------------
    // Result side: check each accepted result transaction, then pick the
    // ready for the next cycle from the current stall rate.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            mirror.check_response(out_data);
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Abort a hung run; the limit covers the store clear after reset too
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Build a request; rwx holds {exec, write, read}
    function automatic ept_in_t request(logic [1:0] op, logic [FRAME_BITS-1:0] pfn,
                                        logic [2:0] rwx);
        ept_in_t req;
        req.opcode      = op;
        req.page_number = pfn;
        req.allow_exec  = rwx[2];
        req.allow_write = rwx[1];
        req.allow_read  = rwx[0];
        return req;
    endfunction

    // Mostly hit regions whose tables exist, so walks reach the leaf level;
    // the rest is noise over the whole frame space and all four opcodes.
    function automatic ept_in_t random_request();
        logic [REGION_BITS-1:0] region;
        logic [1:0]             op;
        int                     pick;
        if ($urandom_range(0, 99) < 20)
            return request(2'($urandom_range(0, 3)), FRAME_BITS'({$urandom(), $urandom()}),
                           3'($urandom_range(0, 7)));
        pick = $urandom_range(0, 9);
        if (pick < 4)
            op = OP_MAP;
        else if (pick < 7)
            op = OP_LOOKUP;
        else if (pick < 9)
            op = OP_PROTECT;
        else
            op = OP_LOOKUP_ALIAS;
        case ($urandom_range(0, 2))
            0:       region = '0;
            1:       region = REGION_BITS'(1);
            default: region = '1;
        endcase
        return request(op, {region, INDEX_BITS'($urandom_range(0, 511))},
                       3'($urandom_range(0, 7)));
    endfunction

    // Present one transaction after a random gap and hold it until accepted
    task automatic push_op(input ept_in_t req);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        mirror.note_request(req);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.owed_results.size() != 0)
            @(posedge clk);
    endtask

    // Change the base only with the unit idle
    task automatic write_base(input logic [FRAME_BITS-1:0] frame);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= frame;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mirror.set_base(frame);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        mirror        = new();
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        cycle_count   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, base at its reset value. Walks through an empty root
        // stop at level 4 as pointers outside the store.
        push_op(request(OP_LOOKUP, '0, 3'b000));
        push_op(request(OP_PROTECT, '0, 3'b111));
        // First map builds the whole path, then look it up and rewrite rwx
        push_op(request(OP_MAP, '0, 3'b000));
        push_op(request(OP_LOOKUP, '0, 3'b000));
        push_op(request(OP_PROTECT, '0, 3'b001));
        push_op(request(OP_PROTECT, '0, 3'b110));
        push_op(request(OP_LOOKUP_ALIAS, '0, 3'b111));
        // Unwritten leaf in an existing leaf table still resolves at level 1
        push_op(request(OP_LOOKUP, FRAME_BITS'(1), 3'b000));
        push_op(request(OP_MAP, FRAME_MAX, 3'b000));
        push_op(request(OP_PROTECT, FRAME_MAX, 3'b101));
        // Shares the upper two levels with frame zero, needs one new table
        push_op(request(OP_MAP, FRAME_BITS'(36'h205), 3'b000));

        // Highest base: old pointers fall outside, new tables use the new base
        write_base(FRAME_MAX);
        push_op(request(OP_LOOKUP, '0, 3'b000));
        push_op(request(OP_MAP, FRAME_BITS'(36'h0_2800_0000), 3'b000));
        push_op(request(OP_LOOKUP, FRAME_BITS'(36'h0_2800_0000), 3'b000));

        // Lowest base of the run, frame one
        write_base(FRAME_BITS'(1));
        push_op(request(OP_MAP, FRAME_BITS'(36'h0_3000_0000), 3'b000));
        push_op(request(OP_PROTECT, FRAME_BITS'(36'h0_3000_0000), 3'b010));

        // Back to the reset base: exhaust the allocator part way down a walk
        write_base(BASE_RESET);
        push_op(request(OP_MAP, FRAME_BITS'(36'h0_3800_0000), 3'b000));
        push_op(request(OP_MAP, FRAME_BITS'(36'h0_3804_0000), 3'b000));
        push_op(request(OP_LOOKUP, FRAME_BITS'(36'h0_3800_0000), 3'b000));
        // Tables built under other bases now point outside the store
        push_op(request(OP_MAP, FRAME_BITS'(36'h0_2800_0000), 3'b000));
        push_op(request(OP_LOOKUP, FRAME_BITS'(36'h0_3000_0000), 3'b000));
        push_op(request(OP_MAP, FRAME_BITS'(2), 3'b000));

        // Random part: no idling, sender idle, receiver stalls, then both
        // with the base shifted one frame down so pointers alias other pages.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 81;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 81;
                end
                default:
                begin
                    write_base(BASE_RESET - FRAME_BITS'(1));
                    send_idle_pct = 30;
                    stall_pct     = 30;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                push_op(random_request());
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ept_pkg.sv
hw/rtl/ept_ram.sv
hw/rtl/ept_walk.sv
hw/rtl/ept_resp_buf.sv
hw/rtl/ept_page_table_map_and_walk_unit.sv
hw/rtl/ept_checker.sv
tb/tb_ept_page_table_map_and_walk_unit.sv
